/* hdl/sphe_pkg.sv */
// Shared types and constants of the sparse polynomial Horner evaluator.
`timescale 1ns / 1ps

package sphe_pkg;

    // Field widths fixed by the item format
    localparam int POLY_W  = 3;
    localparam int EXPO_W  = 6;
    localparam int DATA_W  = 16;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = 64;

    // Operation codes of an input item
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_EVAL   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Status codes of a result item
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // Saturation limits of the Q40.8 accumulator
    localparam logic [ACC_W-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_MIN = 48'h8000_0000_0000;

    // Depth of the command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    // Work kind decided by the front; K_ZERO answers value 0, status ok
    typedef enum logic [1:0] {
        K_ZERO,
        K_INSERT,
        K_EVAL,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [POLY_W-1:0]  poly;
        logic [EXPO_W-1:0]  expo;
        logic [DATA_W-1:0]  coef;
        logic [DATA_W-1:0]  x;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_LOOKUP,
        BS_EVAL,
        BS_DONE
    } t_bstate;

endpackage

/* hdl/sparse_polynomial_horner_evaluator_unit.sv */
// Top level of the sparse polynomial Horner evaluator.
// An evaluation holds the engine for one multiply-accumulate per exponent, from the top exponent
// down to zero; the command queue takes further items while the engine is busy, until it is full.
// A result waits in the result register until it is popped; the engine does not finish its next
// command while that register still holds an unpopped result.
// Reset: the store is swept to zero while full is held high.
`timescale 1ns / 1ps

module sparse_polynomial_horner_evaluator_unit #(
    parameter int unsigned NUM_POLYS    = 8,
    parameter int unsigned MAX_EXPONENT = 63
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input queue side
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_operation,
    input  logic [sphe_pkg::POLY_W-1:0]   i_poly_index,
    input  logic [sphe_pkg::EXPO_W-1:0]   i_exponent,
    input  logic [sphe_pkg::DATA_W-1:0]   i_coefficient,
    input  logic [sphe_pkg::DATA_W-1:0]   i_x_value,
    // Result queue side
    output logic                          empty,
    input  logic                          pop,
    output logic [sphe_pkg::ACC_W-1:0]    o_value,
    output logic [1:0]                    o_status
);

    sphe_pkg::t_cmd w_front_cmd;
    sphe_pkg::t_cmd w_head_cmd;
    logic           w_q_push;
    logic           w_q_pop;
    logic           w_q_full;
    logic           w_q_empty;
    logic           w_clearing;

    // Classify each transfer into a command; full covers a full queue and the clearing sweep
    sphe_front #(
        .NUM_POLYS    (NUM_POLYS),
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_front (
        .i_push        (push),
        .i_operation   (i_operation),
        .i_poly_index  (i_poly_index),
        .i_exponent    (i_exponent),
        .i_coefficient (i_coefficient),
        .i_x_value     (i_x_value),
        .i_q_full      (w_q_full),
        .i_clearing    (w_clearing),
        .o_full        (full),
        .o_q_push      (w_q_push),
        .o_cmd         (w_front_cmd)
    );

    // Decouple intake from the long evaluation runs
    sphe_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_q_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // Execute commands against the store and hold one result for the consumer
    sphe_back #(
        .NUM_POLYS    (NUM_POLYS),
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_cmd      (w_head_cmd),
        .o_q_pop    (w_q_pop),
        .o_clearing (w_clearing),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_value    (o_value),
        .o_status   (o_status)
    );

    // No intake while the store is being cleared
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_clearing |-> full)
        else $error("input accepted during store clearing");

    // Queue never written when full, never read when empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_q_push |-> !w_q_full)
        else $error("command queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_q_pop |-> !w_q_empty)
        else $error("command queue underflow");

    // A duplicate insert reports a zero value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == sphe_pkg::ST_DUP)) |-> (o_value == '0))
        else $error("duplicate insert result carries a nonzero value");

endmodule

/* hdl/sphe_front.sv */
// Front end: accepts input items and classifies them into commands.
`timescale 1ns / 1ps

module sphe_front #(
    parameter int unsigned NUM_POLYS    = 8,
    parameter int unsigned MAX_EXPONENT = 63
) (
    input  logic                               i_push,
    input  logic [1:0]                         i_operation,
    input  logic [sphe_pkg::POLY_W-1:0]        i_poly_index,
    input  logic [sphe_pkg::EXPO_W-1:0]        i_exponent,
    input  logic [sphe_pkg::DATA_W-1:0]        i_coefficient,
    input  logic [sphe_pkg::DATA_W-1:0]        i_x_value,
    input  logic                               i_q_full,
    input  logic                               i_clearing,
    output logic                               o_full,
    output logic                               o_q_push,
    output sphe_pkg::t_cmd                     o_cmd
);

    logic w_poly_ok;
    logic w_slot_ok;

    assign w_poly_ok = 32'(i_poly_index) < NUM_POLYS;
    assign w_slot_ok = w_poly_ok && (32'(i_exponent) <= MAX_EXPONENT);

    always_comb begin
        unique case (i_operation)
            sphe_pkg::OP_INSERT: begin
                o_cmd.kind = w_slot_ok ? sphe_pkg::K_INSERT : sphe_pkg::K_ZERO;
            end
            sphe_pkg::OP_EVAL: begin
                o_cmd.kind = w_poly_ok ? sphe_pkg::K_EVAL : sphe_pkg::K_ZERO;
            end
            sphe_pkg::OP_READ: begin
                o_cmd.kind = w_slot_ok ? sphe_pkg::K_READ : sphe_pkg::K_ZERO;
            end
            default: begin
                o_cmd.kind = sphe_pkg::K_ZERO;
            end
        endcase
        o_cmd.poly = i_poly_index;
        o_cmd.expo = i_exponent;
        o_cmd.coef = i_coefficient;
        o_cmd.x    = i_x_value;
    end

    // Hold off while the queue is full or the store is being cleared
    assign o_full   = i_q_full || i_clearing;
    assign o_q_push = i_push && !o_full;

endmodule

/* hdl/sphe_cmd_fifo.sv */
// Short command queue between the front end and the execution engine.
`timescale 1ns / 1ps

module sphe_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sphe_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output sphe_pkg::t_cmd  o_cmd,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PTR_W = (sphe_pkg::CMDQ_DEPTH > 1) ? $clog2(sphe_pkg::CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(sphe_pkg::CMDQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_P = PTR_W'(sphe_pkg::CMDQ_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(sphe_pkg::CMDQ_DEPTH);

    sphe_pkg::t_cmd   r_slot [sphe_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_cmd   = r_slot[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_C);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == LAST_P) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST_P) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

/* hdl/sphe_back.sv */
// Execution engine: coefficient store, Horner multiply-accumulate and result register.
`timescale 1ns / 1ps

module sphe_back #(
    parameter int unsigned NUM_POLYS    = 8,
    parameter int unsigned MAX_EXPONENT = 63
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  sphe_pkg::t_cmd                i_cmd,
    output logic                          o_q_pop,
    output logic                          o_clearing,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [sphe_pkg::ACC_W-1:0]    o_value,
    output logic [1:0]                    o_status
);

    localparam int SLOTS = MAX_EXPONENT + 1;
    localparam int DEPTH = NUM_POLYS * SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $clog2(SLOTS);
    localparam int MW    = sphe_pkg::DATA_W + 1;
    localparam logic [AW-1:0] SLOTS_A = AW'(SLOTS);
    localparam logic [AW-1:0] TOP_A   = AW'(MAX_EXPONENT);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
    localparam logic [EW-1:0] TOP_E   = EW'(MAX_EXPONENT);

    // Store word: presence bit on top of the coefficient
    logic [MW-1:0]                 r_mem [DEPTH];
    logic [MW-1:0]                 r_rdata;

    sphe_pkg::t_bstate             r_state, n_state;
    logic [AW-1:0]                 r_addr, n_addr;
    logic [EW-1:0]                 r_cnt, n_cnt;
    sphe_pkg::t_kind               r_kind, n_kind;
    logic [sphe_pkg::DATA_W-1:0]   r_coef, n_coef;
    logic [sphe_pkg::DATA_W-1:0]   r_x, n_x;
    logic signed [sphe_pkg::ACC_W-1:0] r_acc, n_acc;
    logic                          r_sat, n_sat;
    logic [1:0]                    r_status, n_status;
    logic                          r_out_valid, n_out_valid;
    logic [sphe_pkg::ACC_W-1:0]    r_out_value, n_out_value;
    logic [1:0]                    r_out_status, n_out_status;

    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [MW-1:0]                 w_wdata;
    logic [AW-1:0]                 w_raddr;
    logic [AW-1:0]                 w_head_addr;

    logic signed [sphe_pkg::DATA_W-1:0] w_x;
    logic [sphe_pkg::DATA_W-1:0]   w_term;
    logic signed [sphe_pkg::PROD_W-1:0] w_prod;
    logic signed [sphe_pkg::PROD_W-1:0] w_cterm;
    logic signed [sphe_pkg::PROD_W-1:0] w_sum;
    logic signed [sphe_pkg::PROD_W-1:0] w_shift;
    logic                          w_ovf_pos;
    logic                          w_ovf_neg;
    logic [sphe_pkg::ACC_W-1:0]    w_clamped;
    logic [sphe_pkg::ACC_W-1:0]    w_read_value;

    // First address of a command: its slot, or the top exponent for an evaluation
    assign w_head_addr = AW'(i_cmd.poly) * SLOTS_A
                       + ((i_cmd.kind == sphe_pkg::K_EVAL) ? TOP_A : AW'(i_cmd.expo));

    // Horner step: floor((acc * x + c * 2^16) / 2^8), then clamp to 48 bits
    assign w_x     = $signed(r_x);
    assign w_term  = r_rdata[MW-1] ? r_rdata[sphe_pkg::DATA_W-1:0] : '0;
    assign w_prod  = r_acc * w_x;
    assign w_cterm = {{32{w_term[sphe_pkg::DATA_W-1]}}, w_term, 16'h0000};
    assign w_sum   = w_prod + w_cterm;
    assign w_shift = w_sum >>> 8;
    assign w_ovf_pos = !w_shift[63] && (|w_shift[62:47]);
    assign w_ovf_neg = w_shift[63] && !(&w_shift[62:47]);
    assign w_clamped = w_ovf_pos ? sphe_pkg::ACC_MAX :
                       w_ovf_neg ? sphe_pkg::ACC_MIN : w_shift[sphe_pkg::ACC_W-1:0];

    assign w_read_value = r_rdata[MW-1] ?
        {{24{r_rdata[sphe_pkg::DATA_W-1]}}, r_rdata[sphe_pkg::DATA_W-1:0], 8'h00} : '0;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_kind       = r_kind;
        n_coef       = r_coef;
        n_x          = r_x;
        n_acc        = r_acc;
        n_sat        = r_sat;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '0;
        w_raddr      = r_addr;
        o_q_pop      = 1'b0;

        if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            sphe_pkg::BS_CLEAR: begin
                w_we = 1'b1;
                if (r_addr == LAST_A) begin
                    n_state = sphe_pkg::BS_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            sphe_pkg::BS_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop  = 1'b1;
                    w_raddr  = w_head_addr;
                    n_addr   = w_head_addr;
                    n_kind   = i_cmd.kind;
                    n_coef   = i_cmd.coef;
                    n_x      = i_cmd.x;
                    n_cnt    = TOP_E;
                    n_acc    = '0;
                    n_sat    = 1'b0;
                    n_status = sphe_pkg::ST_OK;
                    unique case (i_cmd.kind) inside
                        sphe_pkg::K_ZERO: begin
                            n_state = sphe_pkg::BS_DONE;
                        end
                        sphe_pkg::K_EVAL: begin
                            n_state = sphe_pkg::BS_EVAL;
                        end
                        sphe_pkg::K_INSERT, sphe_pkg::K_READ: begin
                            n_state = sphe_pkg::BS_LOOKUP;
                        end
                        default: begin
                            n_state = sphe_pkg::BS_DONE;
                        end
                    endcase
                end
            end
            sphe_pkg::BS_LOOKUP: begin
                if (r_kind == sphe_pkg::K_INSERT) begin
                    n_acc = '0;
                    if (r_rdata[MW-1]) begin
                        n_status = sphe_pkg::ST_DUP;
                    end else begin
                        w_we    = 1'b1;
                        w_wdata = {1'b1, r_coef};
                    end
                end else begin
                    n_acc = w_read_value;
                end
                n_state = sphe_pkg::BS_DONE;
            end
            sphe_pkg::BS_EVAL: begin
                n_acc = w_clamped;
                n_sat = r_sat || w_ovf_pos || w_ovf_neg;
                if (r_cnt == '0) begin
                    n_status = n_sat ? sphe_pkg::ST_SAT : sphe_pkg::ST_OK;
                    n_state  = sphe_pkg::BS_DONE;
                end else begin
                    n_addr  = r_addr - 1'b1;
                    w_raddr = r_addr - 1'b1;
                    n_cnt   = r_cnt - 1'b1;
                end
            end
            sphe_pkg::BS_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_acc;
                    n_out_status = r_status;
                    n_state      = sphe_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = sphe_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sphe_pkg::BS_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_kind       <= n_kind;
        r_coef       <= n_coef;
        r_x          <= n_x;
        r_acc        <= n_acc;
        r_sat        <= n_sat;
        r_status     <= n_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_clearing = (r_state == sphe_pkg::BS_CLEAR);
    assign o_empty    = !r_out_valid;
    assign o_value    = r_out_value;
    assign o_status   = r_out_status;

endmodule
